// File: hw/rtl/als_pkg.sv
package als_pkg;

  // qubit fields carried by one item, one lane each
  localparam int FIELD_QUBITS = 4;
  localparam int SLOT_W       = $clog2(FIELD_QUBITS);
  localparam int COUNT_W      = 3;
  localparam int QUBIT_W      = 6;
  localparam int TARGET_W     = 12;
  localparam int TOTAL_W      = 13;

  typedef struct packed {
    logic               start_circuit;
    logic [COUNT_W-1:0] used_qubits;
    logic [QUBIT_W-1:0] qubit_0;
    logic [QUBIT_W-1:0] qubit_1;
    logic [QUBIT_W-1:0] qubit_2;
    logic [QUBIT_W-1:0] qubit_3;
  } in_item_t;

  typedef struct packed {
    logic [TARGET_W-1:0] placed_layer;
    logic [TOTAL_W-1:0]  layer_total;
    logic                layer_overflow;
  } out_item_t;

endpackage

// File: hw/rtl/als_if.sv
interface als_in_if;
  import als_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface als_out_if;
  import als_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/als_lane.sv
module als_lane #(
  parameter int QUBITS = 64,
  parameter int LW     = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [$clog2(QUBITS)-1:0] rd_addr,
  input  logic                      rd_hit,
  input  logic                      wr_en,
  input  logic [$clog2(QUBITS)-1:0] wr_addr,
  input  logic [LW-1:0]             wr_data,
  output logic [LW-1:0]             rd_data
);

  // private copy of the last-use table, written with every update
  logic [LW-1:0] mem [QUBITS];
  logic [LW-1:0] rdata_r;
  logic          hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= rd_hit;
    end
  end

  // entries not valid or slots not used read as unused
  assign rd_data = hit_r ? rdata_r : '0;

endmodule

// File: hw/rtl/als_merge.sv
module als_merge #(
  parameter int LANES     = 4,
  parameter int LW        = 13,
  parameter int TOP_LAYER = 4095
) (
  input  logic [LW-1:0] lane_val [LANES],
  output logic [LW-1:0] target,
  output logic          overflow
);

  localparam logic [LW-1:0] TOP = LW'(TOP_LAYER);

  logic [LW-1:0] max_v;

  always_comb begin
    max_v = '0;
    for (int k = 0; k < LANES; k++) begin
      if (lane_val[k] > max_v) begin
        max_v = lane_val[k];
      end
    end
    // clip at the last layer
    if (max_v > TOP) begin
      target   = TOP;
      overflow = 1'b1;
    end else begin
      target   = max_v;
      overflow = 1'b0;
    end
  end

endmodule

// File: hw/rtl/asap_layer_scheduler.sv
// asap layer scheduler
// in_ch carries one circuit operation per item: a start flag, a qubit count
// and four qubit indices. out_ch returns one result per item: the layer the
// operation goes into, the running layer count and a saturation flag.
// both channels move an item on a clock edge with valid and ready high.
// each of the four lanes holds its own copy of the per-qubit last-use table
// and looks up one qubit; a merge stage takes the maximum and clips it.
// timing: the item is accepted in idle and the lanes read in that same cycle;
// the merge state registers the clipped maximum, then the write state
// broadcasts the new last-use value slot by slot over the four slots (one
// table write port per lane), then the done state loads the result into the
// output register. no new item is accepted until that result is loaded.
// a result waiting in the output register does not block the next accept;
// a stalled receiver only holds the block in its final state.
// reset (synchronous, active low) clears all per-qubit valid bits and sets
// the layer count to one; a start flag in an item does the same at once.
module asap_layer_scheduler #(
  parameter int QUBITS        = 64,
  parameter int MAX_OP_QUBITS = 4,
  parameter int MAX_LAYERS    = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  als_in_if.sink     in_ch,
  als_out_if.source  out_ch
);
  import als_pkg::*;

  localparam int QW    = $clog2(QUBITS);
  localparam int LW    = $clog2(MAX_LAYERS + 1);
  localparam int LIMIT = (MAX_OP_QUBITS < FIELD_QUBITS) ? MAX_OP_QUBITS : FIELD_QUBITS;
  localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(LIMIT);
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(FIELD_QUBITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_WRITE,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [QUBITS-1:0]   vld_r;
  logic [QW-1:0]       q_r   [FIELD_QUBITS];
  logic [FIELD_QUBITS-1:0] use_r;
  logic [SLOT_W-1:0]   wslot_r;
  logic [LW-1:0]       target_r;
  logic                ovf_r;
  logic [LW-1:0]       total_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                acc;
  logic [COUNT_W-1:0]  cnt;
  logic [QUBIT_W-1:0]  qin   [FIELD_QUBITS];
  logic [QW-1:0]       qa    [FIELD_QUBITS];
  logic [FIELD_QUBITS-1:0] use_in;
  logic [FIELD_QUBITS-1:0] hit_in;
  logic [LW-1:0]       lane_val [FIELD_QUBITS];
  logic [LW-1:0]       mrg_target;
  logic                mrg_ovf;
  logic                wr_en;
  logic [QW-1:0]       wr_addr;
  logic [LW-1:0]       wr_data;
  logic [LW-1:0]       next_total;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // slot decode: count saturation, range check, valid-bit lookup
  always_comb begin
    qin[0] = in_ch.data.qubit_0;
    qin[1] = in_ch.data.qubit_1;
    qin[2] = in_ch.data.qubit_2;
    qin[3] = in_ch.data.qubit_3;
    cnt = (in_ch.data.used_qubits > LIMIT_C) ? LIMIT_C : in_ch.data.used_qubits;
    for (int k = 0; k < FIELD_QUBITS; k++) begin
      qa[k]     = QW'(qin[k]);
      use_in[k] = (COUNT_W'(k) < cnt) && (int'(qin[k]) < QUBITS);
      // a start flag hides every old entry
      hit_in[k] = use_in[k] && !in_ch.data.start_circuit && vld_r[qa[k]];
    end
  end

  // table write broadcast, one slot per cycle
  assign wr_en      = (state_r == S_WRITE) && use_r[wslot_r];
  assign wr_addr    = q_r[wslot_r];
  assign wr_data    = target_r + LW'(1);
  assign next_total = mrg_target + LW'(1);

  for (genvar g = 0; g < FIELD_QUBITS; g++) begin : g_lane
    als_lane #(
      .QUBITS (QUBITS),
      .LW     (LW)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .rd_en   (acc),
      .rd_addr (qa[g]),
      .rd_hit  (hit_in[g]),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (lane_val[g])
    );
  end

  als_merge #(
    .LANES     (FIELD_QUBITS),
    .LW        (LW),
    .TOP_LAYER (MAX_LAYERS - 1)
  ) u_merge (
    .lane_val (lane_val),
    .target   (mrg_target),
    .overflow (mrg_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      wslot_r     <= '0;
      total_r     <= LW'(1);
      out_valid_r <= 1'b0;
    end else begin
      // result taken by the receiver, unless a new one is loaded this cycle
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            for (int k = 0; k < FIELD_QUBITS; k++) begin
              q_r[k] <= qa[k];
            end
            use_r <= use_in;
            if (in_ch.data.start_circuit) begin
              vld_r   <= '0;
              total_r <= LW'(1);
            end
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          target_r <= mrg_target;
          ovf_r    <= mrg_ovf;
          if (next_total > total_r) begin
            total_r <= next_total;
          end
          wslot_r <= '0;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (wr_en) begin
            vld_r[wr_addr] <= 1'b1;
          end
          wslot_r <= wslot_r + SLOT_W'(1);
          if (wslot_r == LAST_SLOT) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // output register free or being emptied this cycle
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.placed_layer    <= TARGET_W'(target_r);
            out_data_r.layer_total     <= TOTAL_W'(total_r);
            out_data_r.layer_overflow  <= ovf_r;
            state_r                    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // layer count always covers the layer just chosen
  a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |=> (total_r > target_r))
    else $error("layer count below chosen layer");

  // a table write marks its qubit as used
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(wr_addr)])
    else $error("written qubit not marked valid");

  // start flag restarts the layer count
  a_start_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.data.start_circuit) |=> (total_r == LW'(1)))
    else $error("start did not reset layer count");

  // no accept while an item is in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ch.ready)
    else $error("accept while busy");

endmodule

// File: tb/als_layer_checker.sv
module als_layer_checker #(
  parameter int QUBITS        = 64,
  parameter int MAX_OP_QUBITS = 4,
  parameter int MAX_LAYERS    = 4096
) (
  input  logic clk,
  input  logic rst_n,
  als_in_if    in_ch,
  als_out_if   out_ch,
  output int   mismatches,
  output int   pending
);
  import als_pkg::*;

  localparam int LANE_CAP = (MAX_OP_QUBITS < FIELD_QUBITS) ? MAX_OP_QUBITS : FIELD_QUBITS;

  // per qubit: last layer that used it, plus one (zero means unused)
  int unsigned last_use_p1 [QUBITS];
  int unsigned layer_count;
  out_item_t   expected_layers [$];

  function automatic out_item_t schedule_op(input in_item_t op);
    logic [QUBIT_W-1:0] lane_q [FIELD_QUBITS];
    int unsigned        n_lanes;
    int unsigned        layer;
    int                 i;
    out_item_t          res;
    if (op.start_circuit) begin
      foreach (last_use_p1[j]) last_use_p1[j] = 0;
      layer_count = 1;
    end
    n_lanes = op.used_qubits;
    if (n_lanes > LANE_CAP) n_lanes = LANE_CAP;
    lane_q[0] = op.qubit_0;
    lane_q[1] = op.qubit_1;
    lane_q[2] = op.qubit_2;
    lane_q[3] = op.qubit_3;
    layer = 0;
    for (i = 0; i < n_lanes; i++) begin
      if (lane_q[i] < QUBITS && last_use_p1[lane_q[i]] > layer)
        layer = last_use_p1[lane_q[i]];
    end
    res.layer_overflow = 1'b0;
    if (layer > MAX_LAYERS - 1) begin
      layer              = MAX_LAYERS - 1;
      res.layer_overflow = 1'b1;
    end
    for (i = 0; i < n_lanes; i++) begin
      if (lane_q[i] < QUBITS) last_use_p1[lane_q[i]] = layer + 1;
    end
    if (layer + 1 > layer_count) layer_count = layer + 1;
    res.placed_layer = TARGET_W'(layer);
    res.layer_total  = TOTAL_W'(layer_count);
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      foreach (last_use_p1[j]) last_use_p1[j] = 0;
      layer_count = 1;
      expected_layers.delete();
    end else begin
      // results first: an item accepted at this edge cannot have its result yet
      if (out_ch.valid && out_ch.ready) begin
        if (expected_layers.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual layer %0d total %0d ovf %0b",
                   $time, out_ch.data.placed_layer, out_ch.data.layer_total,
                   out_ch.data.layer_overflow);
          mismatches++;
        end else begin
          want = expected_layers.pop_front();
          check_field("placed_layer", want.placed_layer, out_ch.data.placed_layer);
          check_field("layer_total", want.layer_total, out_ch.data.layer_total);
          check_field("layer_overflow", want.layer_overflow, out_ch.data.layer_overflow);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_layers.insert(expected_layers.size(), schedule_op(in_ch.data));
    end
    pending = expected_layers.size();
  end

endmodule

// File: tb/asap_layer_scheduler_tb.sv
module asap_layer_scheduler_tb;
  import als_pkg::*;

  localparam int QUBITS        = 64;
  localparam int MAX_OP_QUBITS = 4;
  localparam int MAX_LAYERS    = 4096;
  localparam int LANE_CAP      = (MAX_OP_QUBITS < FIELD_QUBITS) ? MAX_OP_QUBITS : FIELD_QUBITS;

  // random circuits, one long dependency chain on a single qubit, then a closing stretch
  localparam int RANDOM_OPS   = 850;
  localparam int CHAIN_OPS    = 250;
  localparam int CLOSING_OPS  = 180;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 30;
  // watchdog limit for the whole run of roughly 1300 items, with a wide margin
  localparam longint LIMIT_TIME = 64'd2_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  als_in_if  in_ch ();
  als_out_if out_ch ();

  int mismatches;
  int pending_results;

  // idling knobs shared between the sender and the receiver process
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          long_hold = 1'b0;

  asap_layer_scheduler #(
    .QUBITS        (QUBITS),
    .MAX_OP_QUBITS (MAX_OP_QUBITS),
    .MAX_LAYERS    (MAX_LAYERS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  als_layer_checker #(
    .QUBITS        (QUBITS),
    .MAX_OP_QUBITS (MAX_OP_QUBITS),
    .MAX_LAYERS    (MAX_LAYERS)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending_results)
  );

  always #5 clk = ~clk;

  // build one operation item from explicit fields
  function automatic in_item_t mk_op(input bit start, input int unsigned cnt,
                                     input int unsigned q0, input int unsigned q1,
                                     input int unsigned q2, input int unsigned q3);
    in_item_t o;
    o.start_circuit = start;
    o.used_qubits   = COUNT_W'(cnt);
    o.qubit_0       = QUBIT_W'(q0);
    o.qubit_1       = QUBIT_W'(q1);
    o.qubit_2       = QUBIT_W'(q2);
    o.qubit_3       = QUBIT_W'(q3);
    return o;
  endfunction

  // random operation; qubits drawn from 0..span-1, counts mostly 1..4,
  // sometimes zero and sometimes above the lane count
  function automatic in_item_t rand_op(input bit start, input int unsigned span);
    in_item_t    o;
    int unsigned pick;
    pick            = $urandom_range(0, 15);
    o.start_circuit = start;
    if (pick == 0) o.used_qubits = '0;
    else if (pick < 13) o.used_qubits = COUNT_W'((pick - 1) % 4 + 1);
    else o.used_qubits = COUNT_W'(pick - 8);
    o.qubit_0 = QUBIT_W'($urandom_range(0, span - 1));
    o.qubit_1 = QUBIT_W'($urandom_range(0, span - 1));
    o.qubit_2 = QUBIT_W'($urandom_range(0, span - 1));
    o.qubit_3 = QUBIT_W'($urandom_range(0, span - 1));
    return o;
  endfunction

  // idle probability for one stretch: none, light or heavy
  function automatic int unsigned idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // offer one item and hold it until taken; valid stays high unless a gap follows
  task automatic send_op(input in_item_t op);
    in_ch.data  <= op;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop offering until every scheduled operation has reported its layer
  task automatic pause_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    @(posedge clk);
  endtask

  // result side: random stall bursts, plus one long hold on request
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_TIME);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    in_item_t    o;
    int unsigned sent;
    int unsigned span;
    int unsigned len;
    int unsigned lanes;
    int unsigned chain_q;
    int          k;
    bit          hold_done;

    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every qubit count, repeats, start mid-circuit
    gap_pct   = 20;
    stall_pct = 20;
    send_op(mk_op(1, 2, 0, 63, 0, 0));
    send_op(mk_op(0, 0, 63, 63, 63, 63));   // no qubits: layer 0, table untouched
    send_op(mk_op(0, 1, 0, 5, 5, 5));
    send_op(mk_op(0, 4, 0, 63, 1, 2));
    send_op(mk_op(0, 7, 2, 4, 5, 6));       // count above lanes saturates to four
    send_op(mk_op(0, 5, 6, 6, 7, 8));
    send_op(mk_op(0, 6, 7, 9, 10, 11));
    send_op(mk_op(0, 3, 21, 42, 21, 63));   // repeated qubit, alternating bit patterns
    send_op(mk_op(0, 4, 10, 10, 10, 10));   // same qubit in every lane
    send_op(mk_op(0, 2, 10, 10, 0, 0));
    send_op(mk_op(0, 4, 63, 63, 63, 63));
    send_op(mk_op(1, 1, 63, 0, 0, 0));      // start clears a populated table
    send_op(mk_op(1, 0, 0, 0, 0, 0));       // start with no qubits
    send_op(mk_op(0, 1, 0, 0, 0, 0));
    send_op(mk_op(0, 4, 1, 2, 4, 8));
    send_op(mk_op(0, 4, 16, 32, 62, 61));
    send_op(mk_op(1, 7, 63, 62, 61, 60));
    pause_for_results();

    // random circuits: narrow qubit pools build deep dependencies,
    // wide pools exercise every index bit
    sent      = 0;
    hold_done = 1'b0;
    while (sent < RANDOM_OPS) begin
      span      = ($urandom_range(0, 2) == 0) ? QUBITS : $urandom_range(2, 12);
      len       = $urandom_range(4, 60);
      gap_pct   = idle_pct();
      stall_pct = idle_pct();
      for (k = 0; k < len; k++) begin
        // one long receiver hold while items keep coming, to back up the input
        if (!hold_done && sent >= RANDOM_OPS / 3) begin
          hold_done = 1'b1;
          gap_pct   = 0;
          long_hold = 1'b1;
        end
        send_op(rand_op(k == 0 && $urandom_range(0, 7) != 0, span));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) pause_for_results();
    end
    pause_for_results();

    // dependency chain: one qubit in every operation pushes the layer up by
    // at least one each time
    gap_pct   = 5;
    stall_pct = 5;
    chain_q   = $urandom_range(0, QUBITS - 1);
    for (k = 0; k < CHAIN_OPS; k++) begin
      o = rand_op(k == 0, QUBITS);
      if (o.used_qubits == 0) o.used_qubits = 1;
      lanes = (o.used_qubits > LANE_CAP) ? LANE_CAP : o.used_qubits;
      case ($urandom_range(0, lanes - 1))
        0:       o.qubit_0 = QUBIT_W'(chain_q);
        1:       o.qubit_1 = QUBIT_W'(chain_q);
        2:       o.qubit_2 = QUBIT_W'(chain_q);
        default: o.qubit_3 = QUBIT_W'(chain_q);
      endcase
      send_op(o);
    end

    // closing stretch at full rate, no idling on either side
    gap_pct   = 0;
    stall_pct = 0;
    for (k = 0; k < CLOSING_OPS; k++) begin
      send_op(rand_op(k == 0, ($urandom_range(0, 1) == 0) ? QUBITS : 6));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
